// File: rtl/core/rbd_pkg.sv
`default_nettype none
package rbd_pkg;

  localparam int MAX_CELLS_ACROSS = 1024;
  localparam int MAX_CELLS_DOWN   = 1024;
  localparam int BLOCK_SIZE       = 4;

  localparam int COL_W   = $clog2(MAX_CELLS_ACROSS);
  localparam int ROW_W   = $clog2(MAX_CELLS_DOWN);
  localparam int SUB_W   = $clog2(BLOCK_SIZE);
  localparam int DIM_W   = 11;
  localparam int SUM_W   = 7;
  localparam int LEVEL_W = 3;
  localparam int PIX_W   = 8;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 10;
  localparam int RELIEF_W  = 2;
  localparam int M_TDATA_W = 24;

  localparam logic [SUM_W-1:0] RELIEF_DIV = SUM_W'(28);
  localparam logic [SUB_W-1:0] SUB_LAST   = SUB_W'(BLOCK_SIZE - 1);

  typedef enum logic {
    REG_CELLS_ACROSS = 1'b0,
    REG_CELLS_DOWN   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0]   bcol;
    logic [ROW_W-1:0]   brow;
    logic [LEVEL_W-1:0] level;
    logic               first;
    logic               last;
    logic               frame_end;
  } s1_t;

  function automatic logic [RELIEF_W-1:0] relief_of(input logic [SUM_W-1:0] s);
    logic [RELIEF_W-1:0] r;
    if (s >= SUM_W'(3 * 28)) begin
      r = RELIEF_W'(3);
    end else if (s >= SUM_W'(2 * 28)) begin
      r = RELIEF_W'(2);
    end else if (s >= RELIEF_DIV) begin
      r = RELIEF_W'(1);
    end else begin
      r = RELIEF_W'(0);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rbd_ram.sv
`default_nettype none
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/relief_block_downsampler.sv
// relief_block_downsampler
// Input stream: one raster byte per request on s_axis_*, row-major, frame
// 4*cells_across pixels wide and 4*cells_down rows high; bits 7..5 are used.
// Output stream: one request per finished 4x4 block on m_axis_*, carrying
// cell column, cell row and 2-bit relief; tlast marks the final cell.
// Config: cfg_we_i with cfg_idx_i (0 cells_across, 1 cells_down) and
// cfg_wdata_i; any write restarts the frame at the top-left pixel.
// Throughput: one pixel per cycle while the output is not stalled, bounded by
// the single read-modify-write of the per-column accumulator RAM (read on
// acceptance, write as the pixel leaves the s1 register, last write forwarded).
// Result path: the RAM is read on the edge that accepts a block's bottom-right
// pixel; the sum then goes into the output register that drives m_axis_tvalid,
// held back while a previous result still waits for m_axis_tready.
// Reset: position returns to the top-left pixel, dimensions to 64x64, no
// RAM clearing pass; accumulators are written fresh on each block's first
// pixel.
// Back-pressure: the output register holds a result while tready is low;
// pixels keep flowing until a second result is due, then s_axis_tready drops.
`default_nettype none
module relief_block_downsampler
  import rbd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,   // [9:0] cell_col, [19:10] cell_row,
                                                    // [21:20] relief, [23:22] zero
  output logic                      m_axis_tlast,   // frame_done
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i
);

  logic [DIM_W-1:0] across_q, across_d, down_q, down_d;
  logic [COL_W-1:0] across_m1;
  logic [ROW_W-1:0] down_m1;

  logic [COL_W-1:0] bcol_q, bcol_d;
  logic [ROW_W-1:0] brow_q, brow_d;
  logic [SUB_W-1:0] icol_q, icol_d, irow_q, irow_d;

  logic             s1_valid_q, s1_valid_d;
  s1_t              s1_q, s1_d;
  logic             s1_adv, accept, wr_en;

  logic [SUM_W-1:0] rdata, base, sum;
  logic             lw_valid_q;
  logic [COL_W-1:0] lw_addr_q;
  logic [SUM_W-1:0] lw_data_q;

  logic             out_valid_q, out_valid_d;
  logic [OUT_COL_W-1:0] out_col_q;
  logic [OUT_ROW_W-1:0] out_row_q;
  logic [RELIEF_W-1:0]  out_relief_q;
  logic                 out_last_q;

  // clamped dimensions minus one
  always_comb begin
    if (across_q == '0) begin
      across_m1 = '0;
    end else if (across_q > DIM_W'(MAX_CELLS_ACROSS)) begin
      across_m1 = COL_W'(MAX_CELLS_ACROSS - 1);
    end else begin
      across_m1 = COL_W'(across_q - DIM_W'(1));
    end
    if (down_q == '0) begin
      down_m1 = '0;
    end else if (down_q > DIM_W'(MAX_CELLS_DOWN)) begin
      down_m1 = ROW_W'(MAX_CELLS_DOWN - 1);
    end else begin
      down_m1 = ROW_W'(down_q - DIM_W'(1));
    end
  end

  assign s1_adv        = !s1_q.last || !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_valid_q && s1_adv;

  // position counters and config
  always_comb begin
    across_d = across_q;
    down_d   = down_q;
    bcol_d   = bcol_q;
    brow_d   = brow_q;
    icol_d   = icol_q;
    irow_d   = irow_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELLS_ACROSS: across_d = cfg_wdata_i;
        REG_CELLS_DOWN:   down_d   = cfg_wdata_i;
        default:          across_d = across_q;
      endcase
      bcol_d = '0;
      brow_d = '0;
      icol_d = '0;
      irow_d = '0;
    end else if (accept) begin
      icol_d = icol_q + SUB_W'(1);
      if (icol_q == SUB_LAST) begin
        if (bcol_q == across_m1) begin
          bcol_d = '0;
          irow_d = irow_q + SUB_W'(1);
          if (irow_q == SUB_LAST) begin
            brow_d = (brow_q == down_m1) ? '0 : brow_q + ROW_W'(1);
          end
        end else begin
          bcol_d = bcol_q + COL_W'(1);
        end
      end
    end
  end

  always_comb begin
    s1_d.bcol      = bcol_q;
    s1_d.brow      = brow_q;
    s1_d.level     = s_axis_tdata[PIX_W-1 -: LEVEL_W];
    s1_d.first     = (icol_q == '0) && (irow_q == '0);
    s1_d.last      = (icol_q == SUB_LAST) && (irow_q == SUB_LAST);
    s1_d.frame_end = (bcol_q == across_m1) && (brow_q == down_m1);
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  rbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CELLS_ACROSS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_q.bcol),
    .wdata_i (sum),
    .re_i    (accept),
    .raddr_i (bcol_q),
    .rdata_o (rdata)
  );

  // forward the most recent write when it hits the same column; a block's first pixel starts from zero
  always_comb begin
    if (s1_q.first) begin
      base = '0;
    end else if (lw_valid_q && (lw_addr_q == s1_q.bcol)) begin
      base = lw_data_q;
    end else begin
      base = rdata;
    end
    sum = base + SUM_W'(s1_q.level);
  end

  always_comb begin
    if (wr_en && s1_q.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q    <= DIM_W'(64);
      down_q      <= DIM_W'(64);
      bcol_q      <= '0;
      brow_q      <= '0;
      icol_q      <= '0;
      irow_q      <= '0;
      s1_valid_q  <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      across_q    <= across_d;
      down_q      <= down_d;
      bcol_q      <= bcol_d;
      brow_q      <= brow_d;
      icol_q      <= icol_d;
      irow_q      <= irow_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (wr_en) begin
      lw_addr_q <= s1_q.bcol;
      lw_data_q <= sum;
    end
    if (wr_en && s1_q.last) begin
      out_col_q    <= OUT_COL_W'(s1_q.bcol);
      out_row_q    <= OUT_ROW_W'(s1_q.brow);
      out_relief_q <= relief_of(sum);
      out_last_q   <= s1_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_relief_q, out_row_q, out_col_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
